// ===== hw/rtl/cbg_pkg.sv =====
// Shared types, codes and payload structs for the circuit breaker guard.
package cbg_pkg;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_CHECK   = 3'd1,
    MODE_SUCCESS = 3'd2,
    MODE_ERROR   = 3'd3,
    MODE_RESET   = 3'd4,
    MODE_QUERY   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLOSED = 2'd0,
    ST_HALF   = 2'd1,
    ST_OPEN   = 2'd2
  } brk_state_e;

  typedef enum logic [2:0] {
    CAUSE_NONE   = 3'd0,
    CAUSE_PROBE  = 3'd1,
    CAUSE_ERRORS = 3'd2,
    CAUSE_TIME   = 3'd3,
    CAUSE_DEPTH  = 3'd4,
    CAUSE_STEPS  = 3'd5
  } cause_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEPTH_LIMIT     = 3'd0,
    CFG_STEP_LIMIT      = 3'd1,
    CFG_ERROR_RUN_LIMIT = 3'd2,
    CFG_COOLDOWN_TICKS  = 3'd3,
    CFG_RUN_TIME_LIMIT  = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] DepthLimitRst    = 16'd64;
  localparam logic [31:0] StepLimitRst     = 32'd4096;
  localparam logic [15:0] ErrorRunLimitRst = 16'd3;
  localparam logic [31:0] CooldownRst      = 32'd1000;
  localparam logic [31:0] RunTimeLimitRst  = 32'd0;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] depth_now;
    logic [31:0] steps_now;
    logic        in_uncancellable;
  } cbg_in_t;

  typedef struct packed {
    logic        allowed;
    logic        is_tripped;
    logic [1:0]  breaker_state_out;
    logic [2:0]  trip_cause;
    logic [15:0] trip_total_out;
    logic [15:0] error_run_out;
  } cbg_out_t;

  typedef struct packed {
    logic [15:0] depth_limit;
    logic [31:0] step_limit;
    logic [15:0] error_run_limit;
    logic [31:0] cooldown_ticks;
    logic [31:0] run_time_limit;
  } cbg_cfg_t;

  typedef struct packed {
    brk_state_e  brk;
    logic [31:0] uptime;
    logic [31:0] since_trip;
    logic [15:0] error_run;
    logic [15:0] trip_total;
    cause_e      last_cause;
  } cbg_state_t;

endpackage

// ===== hw/rtl/cbg_cfg_regs.sv =====
// Configuration register file of the circuit breaker guard.
module cbg_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cbg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbg_pkg::CfgDataW-1:0] cfg_wdata_i,
  output cbg_pkg::cbg_cfg_t            cfg_o
);
  import cbg_pkg::*;

  cbg_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEPTH_LIMIT:     cfg_d.depth_limit     = cfg_wdata_i[15:0];
        CFG_STEP_LIMIT:      cfg_d.step_limit      = cfg_wdata_i;
        CFG_ERROR_RUN_LIMIT: cfg_d.error_run_limit = cfg_wdata_i[15:0];
        CFG_COOLDOWN_TICKS:  cfg_d.cooldown_ticks  = cfg_wdata_i;
        CFG_RUN_TIME_LIMIT:  cfg_d.run_time_limit  = cfg_wdata_i;
        default:             cfg_d = cfg_q;  // drop writes beyond the map
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_limit     <= DepthLimitRst;
      cfg_q.step_limit      <= StepLimitRst;
      cfg_q.error_run_limit <= ErrorRunLimitRst;
      cfg_q.cooldown_ticks  <= CooldownRst;
      cfg_q.run_time_limit  <= RunTimeLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/cbg_exec.sv =====
// Single-pass evaluation of one item: next breaker state and the result beat.
module cbg_exec (
  input  cbg_pkg::cbg_in_t    item_i,
  input  cbg_pkg::cbg_cfg_t   cfg_i,
  input  cbg_pkg::cbg_state_t state_i,
  output cbg_pkg::cbg_state_t state_o,
  output cbg_pkg::cbg_out_t   res_o
);
  import cbg_pkg::*;

  logic        do_trip;
  cause_e      cause;
  logic        allowed;
  logic        tripped;
  logic [15:0] err_inc;
  logic        err_hit_cur;
  logic        err_hit_inc;
  cbg_state_t  nxt;

  assign err_inc     = (state_i.error_run != '1) ? state_i.error_run + 16'd1
                                                 : state_i.error_run;
  assign err_hit_cur = (cfg_i.error_run_limit != '0) &&
                       (state_i.error_run >= cfg_i.error_run_limit);
  assign err_hit_inc = (cfg_i.error_run_limit != '0) &&
                       (err_inc >= cfg_i.error_run_limit);

  always_comb begin
    nxt     = state_i;
    do_trip = 1'b0;
    cause   = CAUSE_NONE;
    allowed = 1'b0;
    tripped = 1'b0;
    case (mode_e'(item_i.mode))
      MODE_TICK: begin
        if (state_i.uptime != '1)     nxt.uptime     = state_i.uptime + 32'd1;
        if (state_i.since_trip != '1) nxt.since_trip = state_i.since_trip + 32'd1;
      end
      MODE_CHECK: begin
        if ((cfg_i.run_time_limit != '0) && (state_i.uptime > cfg_i.run_time_limit) &&
            !item_i.in_uncancellable) begin
          do_trip = 1'b1;
          cause   = CAUSE_TIME;
        end else if ((cfg_i.depth_limit != '0) &&
                     (item_i.depth_now > cfg_i.depth_limit)) begin
          do_trip = 1'b1;
          cause   = CAUSE_DEPTH;
        end else if ((cfg_i.step_limit != '0) &&
                     (item_i.steps_now > cfg_i.step_limit)) begin
          do_trip = 1'b1;
          cause   = CAUSE_STEPS;
        end else if (err_hit_cur) begin
          do_trip = 1'b1;
          cause   = CAUSE_ERRORS;
        end else if (state_i.brk == ST_OPEN) begin
          if ((cfg_i.cooldown_ticks == '0) ||
              (state_i.since_trip >= cfg_i.cooldown_ticks)) begin
            nxt.brk = ST_HALF;
            allowed = 1'b1;
          end
        end else begin
          allowed = 1'b1;
        end
      end
      MODE_SUCCESS: begin
        if (state_i.brk == ST_HALF) nxt.brk = ST_CLOSED;
        nxt.error_run = '0;
      end
      MODE_ERROR: begin
        if (state_i.brk == ST_HALF) begin
          do_trip = 1'b1;
          cause   = CAUSE_PROBE;
        end else begin
          nxt.error_run = err_inc;
          if (err_hit_inc) begin
            do_trip = 1'b1;
            cause   = CAUSE_ERRORS;
          end else begin
            allowed = 1'b1;
          end
        end
      end
      MODE_RESET: begin
        nxt.brk        = ST_CLOSED;
        nxt.uptime     = '0;
        nxt.since_trip = '0;
        nxt.error_run  = '0;
        nxt.last_cause = CAUSE_NONE;
      end
      MODE_QUERY: begin
        tripped = ((state_i.brk == ST_OPEN) && (cfg_i.cooldown_ticks != '0) &&
                   (state_i.since_trip < cfg_i.cooldown_ticks)) ||
                  ((cfg_i.run_time_limit != '0) &&
                   (state_i.uptime >= cfg_i.run_time_limit)) ||
                  ((cfg_i.depth_limit != '0) &&
                   (item_i.depth_now > cfg_i.depth_limit)) ||
                  ((cfg_i.step_limit != '0) &&
                   (item_i.steps_now >= cfg_i.step_limit)) ||
                  err_hit_cur;
      end
      default: begin
        nxt = state_i;  // unused modes hold everything
      end
    endcase

    if (do_trip) begin
      nxt.brk        = ST_OPEN;
      nxt.since_trip = '0;
      if (state_i.trip_total != '1) nxt.trip_total = state_i.trip_total + 16'd1;
      nxt.last_cause = cause;
    end
  end

  assign state_o = nxt;

  assign res_o.allowed           = allowed;
  assign res_o.is_tripped        = tripped;
  assign res_o.breaker_state_out = nxt.brk;
  assign res_o.trip_cause        = nxt.last_cause;
  assign res_o.trip_total_out    = nxt.trip_total;
  assign res_o.error_run_out     = nxt.error_run;

endmodule

// ===== hw/rtl/circuit_breaker_guard_unit.sv =====
// Top level of the circuit breaker guard: input stage, breaker state, result stage.
// Path: an input beat goes through the input register, then the result register
// written by the single-pass evaluation in cbg_exec, to its result beat.
// Throughput: one item per cycle unless out_ready_i stalls; the input register refills in the cycle it drains.
// Reset: rst_ni clears the breaker state, trip count and both stage valid bits,
// and loads the configuration registers with their documented defaults.
module circuit_breaker_guard_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [cbg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbg_pkg::CfgDataW-1:0] cfg_wdata_i,
  // item input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cbg_pkg::cbg_in_t             in_data_i,
  // result output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cbg_pkg::cbg_out_t            out_data_o
);
  import cbg_pkg::*;

  cbg_cfg_t   cfg;

  // Input stage: one beat held until the evaluation takes it.
  logic       in_valid_q, in_valid_d;
  cbg_in_t    in_data_q;

  // Breaker state, updated in the cycle an item is evaluated.
  cbg_state_t state_q, state_d;

  // Result stage.
  logic       out_valid_q, out_valid_d;
  cbg_out_t   out_data_q, res;

  logic       exec_fire;
  logic       in_fire;

  cbg_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cbg_exec u_exec (
    .item_i  (in_data_q),
    .cfg_i   (cfg),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res)
  );

  // Evaluate when an item waits and the result slot is free or draining.
  assign exec_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || exec_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (exec_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      state_q.brk         <= ST_CLOSED;
      state_q.uptime      <= '0;
      state_q.since_trip  <= '0;
      state_q.error_run   <= '0;
      state_q.trip_total  <= '0;
      state_q.last_cause  <= CAUSE_NONE;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (exec_fire) begin
        state_q <= state_d;  // advance the breaker with the evaluated item
      end
    end
  end

  // Payload registers: capture on the handshake, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= in_data_i;
    end
    if (exec_fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An evaluated item always shows up as a result beat in the next cycle.
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> out_valid_o)
    else $error("evaluated item did not produce a result beat");

  // The trip count only grows while the block runs.
  a_trip_total_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> state_q.trip_total >= $past(state_q.trip_total))
    else $error("trip count went down");

  // No result both allows work and reports tripped.
  a_allow_xor_trip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.allowed && out_data_o.is_tripped))
    else $error("result both allowed and tripped");

  // A waiting item that is not evaluated stays in the input stage.
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !exec_fire) |=> in_valid_q)
    else $error("input stage lost an item");

endmodule

// ===== tb/sv/circuit_breaker_guard_unit_test.sv =====
// Self-checking testbench for circuit_breaker_guard_unit: directed and random beats.
`timescale 1ns / 1ps

module circuit_breaker_guard_unit_test;
  import cbg_pkg::*;

  // Mode codes outside the defined set; the block must answer them without side effects.
  localparam logic [2:0] ModeSpareLo = 3'd6;
  localparam logic [2:0] ModeSpareHi = 3'd7;
  // First register index past the defined set; writes there must be dropped.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd5;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned BeatsPerPhase = 90;
  localparam int unsigned NumPhases = 8;

  // Shadow of the breaker: tracks config and state, predicts one result per beat.
  class breaker_tracker;
    cbg_cfg_t    cfg;
    brk_state_e  brk;
    logic [31:0] uptime;
    logic [31:0] since_trip;
    logic [15:0] err_run;
    logic [15:0] trips;
    cause_e      cause;
    cbg_out_t    verdict_q[$];
    int unsigned mismatches;
    int unsigned beats_noted;
    int unsigned verdicts_checked;
    int unsigned trips_made;
    int unsigned probes_granted;
    int unsigned recloses;

    function new();
      cfg.depth_limit     = DepthLimitRst;
      cfg.step_limit      = StepLimitRst;
      cfg.error_run_limit = ErrorRunLimitRst;
      cfg.cooldown_ticks  = CooldownRst;
      cfg.run_time_limit  = RunTimeLimitRst;
      brk        = ST_CLOSED;
      uptime     = '0;
      since_trip = '0;
      err_run    = '0;
      trips      = '0;
      cause      = CAUSE_NONE;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_DEPTH_LIMIT:     cfg.depth_limit     = data[15:0];
        CFG_STEP_LIMIT:      cfg.step_limit      = data;
        CFG_ERROR_RUN_LIMIT: cfg.error_run_limit = data[15:0];
        CFG_COOLDOWN_TICKS:  cfg.cooldown_ticks  = data;
        CFG_RUN_TIME_LIMIT:  cfg.run_time_limit  = data;
        default: ;
      endcase
    endfunction

    function bit errors_at_limit();
      return cfg.error_run_limit != 0 && err_run >= cfg.error_run_limit;
    endfunction

    function void open_breaker(cause_e why);
      brk        = ST_OPEN;
      since_trip = '0;
      if (trips != 16'hFFFF) trips++;
      cause = why;
      trips_made++;
    endfunction

    // Advance the shadow state by one accepted beat and queue the result it must produce.
    function void note_item(cbg_in_t it);
      cbg_out_t v;
      v = '0;
      beats_noted++;
      case (it.mode)
        MODE_TICK: begin
          if (uptime != '1) uptime++;
          if (since_trip != '1) since_trip++;
        end
        MODE_CHECK: begin
          // First limit hit wins; run time is skipped inside an uncancellable section.
          if (cfg.run_time_limit != 0 && uptime > cfg.run_time_limit && !it.in_uncancellable)
            open_breaker(CAUSE_TIME);
          else if (cfg.depth_limit != 0 && it.depth_now > cfg.depth_limit)
            open_breaker(CAUSE_DEPTH);
          else if (cfg.step_limit != 0 && it.steps_now > cfg.step_limit)
            open_breaker(CAUSE_STEPS);
          else if (errors_at_limit())
            open_breaker(CAUSE_ERRORS);
          else if (brk == ST_OPEN) begin
            if (cfg.cooldown_ticks == 0 || since_trip >= cfg.cooldown_ticks) begin
              brk       = ST_HALF;
              v.allowed = 1'b1;
              probes_granted++;
            end
          end else begin
            v.allowed = 1'b1;
          end
        end
        MODE_SUCCESS: begin
          if (brk == ST_HALF) begin
            brk = ST_CLOSED;
            recloses++;
          end
          err_run = '0;
        end
        MODE_ERROR: begin
          if (brk == ST_HALF) begin
            open_breaker(CAUSE_PROBE);
          end else begin
            if (err_run != '1) err_run++;
            if (errors_at_limit()) open_breaker(CAUSE_ERRORS);
            else v.allowed = 1'b1;
          end
        end
        MODE_RESET: begin
          brk        = ST_CLOSED;
          uptime     = '0;
          since_trip = '0;
          err_run    = '0;
          cause      = CAUSE_NONE;
        end
        MODE_QUERY: begin
          // Inclusive tests, except depth which stays strict.
          v.is_tripped = (brk == ST_OPEN && cfg.cooldown_ticks != 0 &&
                          since_trip < cfg.cooldown_ticks) ||
                         (cfg.run_time_limit != 0 && uptime >= cfg.run_time_limit) ||
                         (cfg.depth_limit != 0 && it.depth_now > cfg.depth_limit) ||
                         (cfg.step_limit != 0 && it.steps_now >= cfg.step_limit) ||
                         errors_at_limit();
        end
        default: ;
      endcase
      v.breaker_state_out = brk;
      v.trip_cause        = cause;
      v.trip_total_out    = trips;
      v.error_run_out     = err_run;
      verdict_q.push_back(v);
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("[%0t] mismatch on result %0d, %s: got 0x%0h, want 0x%0h",
               $realtime, verdicts_checked, what, got, want);
    endtask

    task check_verdict(cbg_out_t got);
      cbg_out_t want;
      if (verdict_q.size() == 0) begin
        report_mismatch("result with nothing pending", got, 0);
        return;
      end
      want = verdict_q.pop_front();
      if (got.allowed !== want.allowed)
        report_mismatch("allowed", got.allowed, want.allowed);
      if (got.is_tripped !== want.is_tripped)
        report_mismatch("is_tripped", got.is_tripped, want.is_tripped);
      if (got.breaker_state_out !== want.breaker_state_out)
        report_mismatch("breaker_state_out", got.breaker_state_out, want.breaker_state_out);
      if (got.trip_cause !== want.trip_cause)
        report_mismatch("trip_cause", got.trip_cause, want.trip_cause);
      if (got.trip_total_out !== want.trip_total_out)
        report_mismatch("trip_total_out", got.trip_total_out, want.trip_total_out);
      if (got.error_run_out !== want.error_run_out)
        report_mismatch("error_run_out", got.error_run_out, want.error_run_out);
      verdicts_checked++;
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  cbg_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  cbg_out_t             out_data_o;

  breaker_tracker brk_trk;
  int unsigned    send_gap_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    cycle_count = 0;

  circuit_breaker_guard_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Stall the result channel at the current rate; drive on the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result beat against the oldest pending prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) brk_trk.check_verdict(out_data_o);
  end

  // Hard stop if the block hangs or drops results.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, brk_trk.verdict_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic cbg_in_t beat_of(logic [2:0] mode, logic [15:0] depth,
                                      logic [31:0] steps, logic uncancel);
    cbg_in_t it;
    it.mode             = mode;
    it.depth_now        = depth;
    it.steps_now        = steps;
    it.in_uncancellable = uncancel;
    return it;
  endfunction

  // Mostly at or under the limit so checks get past the trip tests; some right at the
  // boundary, a few fully random so every bit toggles.
  function automatic logic [31:0] pick_level(logic [31:0] lim);
    int unsigned r;
    r = $urandom_range(9);
    if (r < 7) return (lim == 0) ? $urandom_range(20) : $urandom_range(lim);
    if (r < 9) return lim + $urandom_range(2) - 1;
    return $urandom();
  endfunction

  function automatic cbg_in_t random_beat(cbg_cfg_t c);
    cbg_in_t     it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 28)      it.mode = MODE_TICK;
    else if (pick < 52) it.mode = MODE_CHECK;
    else if (pick < 62) it.mode = MODE_SUCCESS;
    else if (pick < 74) it.mode = MODE_ERROR;
    else if (pick < 77) it.mode = MODE_RESET;
    else if (pick < 95) it.mode = MODE_QUERY;
    else                it.mode = $urandom_range(1) ? ModeSpareHi : ModeSpareLo;
    it.depth_now        = 16'(pick_level({16'd0, c.depth_limit}));
    it.steps_now        = pick_level(c.step_limit);
    it.in_uncancellable = ($urandom_range(99) < 35);
    return it;
  endfunction

  // Present one beat, with random leading gaps; returns on the falling edge after accept.
  task automatic send_item(cbg_in_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    brk_trk.note_item(it);
    @(negedge clk_i);
  endtask

  // Drop valid, wait out every pending result, then let the pipe settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (brk_trk.verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    brk_trk.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Write all five limits plus one stray index that must be ignored.
  task automatic apply_settings(logic [15:0] depth, logic [31:0] steps, logic [15:0] errs,
                                logic [31:0] cool, logic [31:0] run_time);
    write_reg(CFG_DEPTH_LIMIT, {16'd0, depth});
    write_reg(CFG_STEP_LIMIT, steps);
    write_reg(CFG_ERROR_RUN_LIMIT, {16'd0, errs});
    write_reg(CFG_COOLDOWN_TICKS, cool);
    write_reg(CFG_RUN_TIME_LIMIT, run_time);
    write_reg(CfgIdxSpare + CfgIdxW'($urandom_range(2)), $urandom());
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    brk_trk     = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset limits: boundaries of the strict check tests against the inclusive query,
    // depth, step and error trips, refusal while cooling down, error run, spare mode, reset beat.
    send_item(beat_of(MODE_QUERY, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_QUERY, 16'd64, 32'd4096, 1'b0));
    send_item(beat_of(MODE_CHECK, 16'd64, 32'd4096, 1'b0));
    send_item(beat_of(MODE_CHECK, 16'hFFFF, 32'd0, 1'b0));
    send_item(beat_of(MODE_CHECK, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_QUERY, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_CHECK, 16'd0, 32'hFFFF_FFFF, 1'b1));
    send_item(beat_of(MODE_ERROR, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_ERROR, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_ERROR, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_CHECK, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_SUCCESS, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(ModeSpareLo, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    send_item(beat_of(MODE_RESET, 16'd0, 32'd0, 1'b0));
    drain_results();

    // Tight limits with zero cooldown: run-time trip and its uncancellable bypass,
    // immediate half-open probe, failed probe, successful probe.
    apply_settings(16'd10, 32'd100, 16'd2, 32'd0, 32'd2);
    repeat (3) send_item(beat_of(MODE_TICK, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_CHECK, 16'd10, 32'd100, 1'b1));
    send_item(beat_of(MODE_QUERY, 16'd10, 32'd100, 1'b0));
    send_item(beat_of(MODE_CHECK, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_CHECK, 16'd0, 32'd0, 1'b1));
    send_item(beat_of(MODE_ERROR, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_CHECK, 16'd0, 32'd0, 1'b1));
    send_item(beat_of(MODE_SUCCESS, 16'd0, 32'd0, 1'b0));
    send_item(beat_of(MODE_RESET, 16'd0, 32'd0, 1'b0));
    drain_results();

    // Random phases: rotate through settings and idling patterns.
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: apply_settings(16'd8, 32'd200, 16'd2, 32'd4, 32'd60);
        1: apply_settings(16'd0, 32'd0, 16'd0, 32'd0, 32'd0);
        2: apply_settings(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: apply_settings(16'd1, 32'd1, 16'd1, 32'd1, 32'd1);
        4: apply_settings(16'($urandom_range(40, 1)), $urandom_range(500, 1),
                          16'($urandom_range(5, 1)), $urandom_range(12),
                          $urandom_range(150));
        5: apply_settings(16'd64, 32'd4096, 16'd3, 32'd3, 32'd0);
        6: apply_settings(16'($urandom()), $urandom(), 16'($urandom()), $urandom(),
                          $urandom());
        default: apply_settings(16'd5, 32'd50, 16'd4, 32'd6, 32'd90);
      endcase
      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 83; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 83; end
        default: begin send_gap_pct = 8; recv_stall_pct = 8; end
      endcase
      repeat (BeatsPerPhase) send_item(random_beat(brk_trk.cfg));
      drain_results();
    end

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    while (brk_trk.verdict_q.size() != 0) begin
      brk_trk.report_mismatch("result never arrived", 0, brk_trk.verdict_q.pop_front());
    end

    $display("covered %0d beats over %0d random settings plus two directed sets",
             brk_trk.beats_noted, NumPhases);
    $display("checked %0d results: %0d trips, %0d probes granted, %0d re-closed",
             brk_trk.verdicts_checked, brk_trk.trips_made, brk_trk.probes_granted,
             brk_trk.recloses);
    if (brk_trk.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== circuit_breaker_guard_unit.f =====
hw/rtl/cbg_pkg.sv
hw/rtl/cbg_cfg_regs.sv
hw/rtl/cbg_exec.sv
hw/rtl/circuit_breaker_guard_unit.sv
tb/sv/circuit_breaker_guard_unit_test.sv
